@@ src/cdr_bob_pkg.sv @@
// Shared types and constants for the byte order buffer engine.
package cdr_bob_pkg;

  localparam int BUF_DEPTH_DEF = 4096;
  localparam int LANES = 8;
  localparam int LEN_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_ALIGN  = 2'd2;
  localparam logic [1:0] CMD_REWIND = 2'd3;

  localparam logic [1:0] ORD_BIG    = 2'd1;
  localparam logic [1:0] ORD_LITTLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_LEN    = 1'd1;

  localparam logic [LEN_W-1:0] BUF_LEN_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  width_code;
    logic [1:0]  order_select;
    logic [63:0] write_value;
    logic [3:0]  align_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0]      read_value;
    logic             status;
    logic [LEN_W-1:0] cursor_position;
  } out_item_t;

endpackage

@@ src/cdr_bob_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cdr_bob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/cdr_byte_order_buffer_engine.sv @@
// Read, write and rewind pass from idle through S_ACCESS, where done and the result are registered;
// busy holds off any new request until the engine is idle again. The eight byte banks have a
// registered read. Align runs a bit-serial remainder over the 13-bit cursor, one request at a
// time. The receiver cannot stall done.
// Reset clears the cursor, sets little endian and a length of 4096; the byte banks are
// not cleared and hold undefined data until written.
module cdr_byte_order_buffer_engine
  import cdr_bob_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BANK_DEPTH = (BUF_DEPTH + LANES - 1) / LANES;
  localparam int ROW_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CAP = (BUF_DEPTH < 8191) ? BUF_DEPTH : 8191;
  localparam logic [LEN_W-1:0] CAP_V = LEN_W'(CAP);
  localparam logic [3:0] DIV_LAST = 4'(LEN_W - 1);

  typedef enum logic [1:0] {S_IDLE, S_ACCESS, S_DIV} state_t;

  state_t           state;
  logic [LEN_W-1:0] cursor;
  logic             default_order;
  logic [LEN_W-1:0] buffer_length;

  // access context held for the data cycle
  logic       acc_read;
  logic       acc_status;
  logic [2:0] acc_base;
  logic [3:0] acc_size;
  logic       acc_little;

  // remainder unit
  logic [3:0] div_d;
  logic [3:0] rem;
  logic [3:0] cnt;

  logic             accept;
  logic [LEN_W-1:0] eff_len;
  logic [3:0]       size_bytes;
  logic             little;
  logic             fit;
  logic [2:0]       lane_j   [LANES];
  logic [ROW_W-1:0] row      [LANES];
  logic             bank_we  [LANES];
  logic [7:0]       bank_wd  [LANES];
  logic [7:0]       bank_rd  [LANES];
  logic [63:0]      read_asm;
  logic [4:0]       rem_t;
  logic [3:0]       rem_step;
  logic [LEN_W-1:0] cursor_aligned;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    eff_len = (buffer_length > CAP_V) ? CAP_V : buffer_length;
    size_bytes = 4'd1 << item.width_code;
    if (item.order_select == ORD_BIG) begin
      little = 1'b0;
    end else if (item.order_select == ORD_LITTLE) begin
      little = 1'b1;
    end else begin
      little = default_order;
    end
    fit = ({1'b0, cursor} + 14'(size_bytes)) <= {1'b0, eff_len};
  end

  // Each bank holds the bytes whose address is congruent to its index mod 8, so any
  // eight consecutive bytes touch each bank exactly once.
  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [13:0] addr;
    logic [2:0]  sig;

    always_comb begin
      lane_j[b] = 3'(b) - cursor[2:0];
      addr      = {1'b0, cursor} + 14'(lane_j[b]);
      row[b]    = ROW_W'(addr[13:3]);
      sig       = little ? lane_j[b] : (3'(size_bytes - 4'd1) - lane_j[b]);
      bank_wd[b] = item.write_value[8*sig +: 8];
      bank_we[b] = accept && (item.cmd == CMD_WRITE) && fit
                   && ({1'b0, lane_j[b]} < size_bytes);
    end

    cdr_bob_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we[b]),
      .waddr(row[b]),
      .wdata(bank_wd[b]),
      .raddr(row[b]),
      .rdata(bank_rd[b])
    );
  end

  // Gather the value bytes from the banks in significance order.
  always_comb begin
    logic [2:0] j;
    logic [2:0] bank;
    read_asm = '0;
    for (int k = 0; k < LANES; k++) begin
      j    = acc_little ? 3'(k) : (3'(acc_size - 4'd1) - 3'(k));
      bank = acc_base + j;
      if (4'(k) < acc_size) begin
        read_asm[8*k +: 8] = bank_rd[bank];
      end
    end
  end

  always_comb begin
    rem_t    = {rem, cursor[cnt]};
    rem_step = (rem_t >= {1'b0, div_d}) ? 4'(rem_t - {1'b0, div_d}) : rem_t[3:0];
    cursor_aligned = (rem_step == 4'd0) ? cursor
                   : (cursor + LEN_W'(div_d) - LEN_W'(rem_step));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_order <= 1'b1;
      buffer_length <= BUF_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BYTE_ORDER: default_order <= cfg_data[0];
        REG_BUF_LEN:    buffer_length <= cfg_data;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      cursor <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            acc_read   <= (item.cmd == CMD_READ) && fit;
            acc_status <= ((item.cmd == CMD_READ) || (item.cmd == CMD_WRITE)) && !fit;
            acc_base   <= cursor[2:0];
            acc_size   <= size_bytes;
            acc_little <= little;
            case (item.cmd)
              CMD_WRITE, CMD_READ: begin
                if (fit) begin
                  cursor <= cursor + LEN_W'(size_bytes);
                end
                state <= S_ACCESS;
              end
              CMD_ALIGN: begin
                // treat a zero boundary as one
                div_d <= (item.align_bytes == 4'd0) ? 4'd1 : item.align_bytes;
                rem   <= '0;
                cnt   <= DIV_LAST;
                state <= S_DIV;
              end
              CMD_REWIND: begin
                cursor <= '0;
                state  <= S_ACCESS;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ACCESS: begin
          done                   <= 1'b1;
          result.read_value      <= acc_read ? read_asm : 64'd0;
          result.status          <= acc_status;
          result.cursor_position <= cursor;
          state                  <= S_IDLE;
        end
        S_DIV: begin
          rem <= rem_step;
          if (cnt == 4'd0) begin
            cursor                 <= cursor_aligned;
            done                   <= 1'b1;
            result.read_value      <= 64'd0;
            result.status          <= 1'b0;
            result.cursor_position <= cursor_aligned;
            state                  <= S_IDLE;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.read_value == 64'd0))
    else $error("refused access returned data");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request taken without going busy");

  a_rewind_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.cmd == CMD_REWIND)) |-> ##2 (done && (result.cursor_position == '0)))
    else $error("rewind did not clear the cursor");
`endif

endmodule

@@ tb/cdr_byte_order_buffer_engine_test.sv @@
// Self-checking testbench for the byte order buffer engine: directed and random requests.
module cdr_byte_order_buffer_engine_test;
  import cdr_bob_pkg::*;

  typedef struct packed {
    in_item_t  rq;
    out_item_t exp;
  } req_pair_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              item = '0;
  logic                  done;
  out_item_t             result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the engine, advanced as requests are queued
  logic [7:0]       shadow_mem [BUF_DEPTH_DEF];
  bit               byte_valid [BUF_DEPTH_DEF];
  logic [LEN_W-1:0] cur_pos = '0;
  logic             cfg_little = 1'b1;
  logic [LEN_W-1:0] cfg_len = BUF_LEN_RESET;

  req_pair_t pending_q [$];
  out_item_t expect_q [$];
  out_item_t live_exp;
  int        gap_left = 0;
  int        burst_left = 1;
  int        bad_count = 0;

  cdr_byte_order_buffer_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned usable_len();
    return (cfg_len > BUF_DEPTH_DEF) ? BUF_DEPTH_DEF : cfg_len;
  endfunction

  function automatic out_item_t apply_request(in_item_t rq);
    out_item_t   res;
    int unsigned nbytes, pos, addr, lane, al, k;
    logic        little;
    res = '0;
    nbytes = 1 << rq.width_code;
    pos = cur_pos;
    case (rq.order_select)
      ORD_BIG:    little = 1'b0;
      ORD_LITTLE: little = 1'b1;
      default:    little = cfg_little;
    endcase
    case (rq.cmd)
      CMD_WRITE, CMD_READ: begin
        if (pos + nbytes > usable_len()) begin
          res.status = 1'b1;
        end else begin
          for (k = 0; k < nbytes; k++) begin
            lane = little ? k : nbytes - 1 - k;
            addr = pos + lane;
            if (addr < BUF_DEPTH_DEF) begin
              if (rq.cmd == CMD_WRITE) begin
                shadow_mem[addr] = rq.write_value[8*k +: 8];
                byte_valid[addr] = 1'b1;
              end else begin
                res.read_value[8*k +: 8] = shadow_mem[addr];
              end
            end
          end
          pos = (pos + nbytes) & 32'h1FFF;
        end
      end
      CMD_ALIGN: begin
        al = (rq.align_bytes == 0) ? 1 : rq.align_bytes;
        if (pos % al != 0) pos = (pos + al - pos % al) & 32'h1FFF;
      end
      default: pos = 0;
    endcase
    cur_pos = LEN_W'(pos);
    res.cursor_position = cur_pos;
    return res;
  endfunction

  // a read that passes the length check must only touch written bytes
  function automatic bit read_covered(in_item_t rq);
    int unsigned nbytes, k;
    nbytes = 1 << rq.width_code;
    if (cur_pos + nbytes > usable_len()) return 1'b1;
    for (k = 0; k < nbytes; k++)
      if (!byte_valid[cur_pos + k]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic in_item_t make_req(logic [1:0] c, logic [1:0] w, logic [1:0] o,
                                        logic [63:0] v, logic [3:0] a);
    in_item_t rq;
    rq.cmd = c;
    rq.width_code = w;
    rq.order_select = o;
    rq.write_value = v;
    rq.align_bytes = a;
    return rq;
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 64'h0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_req(in_item_t rq);
    req_pair_t p;
    if (rq.cmd == CMD_READ && !read_covered(rq)) rq.cmd = CMD_WRITE;
    p.rq = rq;
    p.exp = apply_request(rq);
    pending_q.push_back(p);
  endtask

  task automatic queue_random(logic [1:0] c);
    queue_req(make_req(c, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       rand_value(), 4'($urandom_range(0, 15))));
  endtask

  // wait until no request is queued, in flight or awaiting its result
  task automatic drain();
    while (pending_q.size() != 0 || start || expect_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BYTE_ORDER) cfg_little = val[0];
    else cfg_len = val;
  endtask

  task automatic set_config(logic little, logic [LEN_W-1:0] len);
    drain();
    write_reg(REG_BYTE_ORDER, CFG_DATA_W'(little));
    write_reg(REG_BUF_LEN, len);
  endtask

  // write a few values from a fresh base, rewind, read them back
  task automatic queue_round_trip();
    int n, i;
    n = $urandom_range(1, 8);
    queue_req(make_req(CMD_REWIND, 2'd0, 2'd0, 64'h0, 4'd0));
    if ($urandom_range(0, 1)) queue_random(CMD_ALIGN);
    for (i = 0; i < n; i++) begin
      queue_random(CMD_WRITE);
      if ($urandom_range(0, 4) == 0) queue_random(CMD_ALIGN);
    end
    queue_req(make_req(CMD_REWIND, 2'd0, 2'd0, 64'h0, 4'd0));
    n = n + $urandom_range(0, 2);
    for (i = 0; i < n; i++) queue_random(CMD_READ);
  endtask

  always @(posedge clk) begin
    req_pair_t nxt;
    logic      go;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expect_q.push_back(live_exp);
      if (start && busy) begin
        go = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        item <= nxt.rq;
        live_exp <= nxt.exp;
        go = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      start <= go;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done) begin
      if (expect_q.size() == 0) begin
        if (bad_count < 10) $display("unexpected result: %p", result);
        bad_count++;
      end else begin
        want = expect_q.pop_front();
        if (result.read_value !== want.read_value || result.status !== want.status ||
            result.cursor_position !== want.cursor_position) begin
          if (bad_count < 10)
            $display("mismatch: read_value %h/%h status %b/%b cursor %0d/%0d (exp/act)",
                     want.read_value, result.read_value, want.status, result.status,
                     want.cursor_position, result.cursor_position);
          bad_count++;
        end
      end
    end
  end

  initial begin
    int          ph, i;
    logic [12:0] len_plan [8];
    len_plan = '{13'd4096, 13'd1, 13'd4095, 13'd13, 13'd64, 13'd0, 13'd0, 13'd4096};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: little endian default, full length
    queue_req(make_req(CMD_WRITE, 2'd3, 2'd0, '1, 4'd0));
    queue_req(make_req(CMD_WRITE, 2'd3, ORD_BIG, 64'h0123_4567_89AB_CDEF, 4'd0));
    queue_req(make_req(CMD_WRITE, 2'd1, ORD_LITTLE, 64'hDEAD_BEEF_0000_A55A, 4'd0));
    queue_req(make_req(CMD_WRITE, 2'd2, 2'd3, 64'hCAFE_F00D_8765_4321, 4'd0));
    queue_req(make_req(CMD_WRITE, 2'd0, ORD_BIG, 64'h0, 4'd0));
    queue_req(make_req(CMD_ALIGN, 2'd0, 2'd0, 64'h0, 4'd0));
    queue_req(make_req(CMD_ALIGN, 2'd0, 2'd0, 64'h0, 4'd15));
    queue_req(make_req(CMD_ALIGN, 2'd0, 2'd0, 64'h0, 4'd8));
    queue_req(make_req(CMD_REWIND, 2'd0, 2'd0, 64'h0, 4'd0));
    queue_req(make_req(CMD_READ, 2'd3, 2'd0, 64'h0, 4'd0));
    queue_req(make_req(CMD_READ, 2'd3, ORD_BIG, 64'h0, 4'd0));
    queue_req(make_req(CMD_READ, 2'd1, ORD_LITTLE, 64'h0, 4'd0));
    queue_req(make_req(CMD_READ, 2'd2, 2'd3, 64'h0, 4'd0));
    queue_req(make_req(CMD_READ, 2'd0, ORD_BIG, 64'h0, 4'd0));

    // zero length: every access refused
    set_config(1'b0, 13'd0);
    queue_req(make_req(CMD_WRITE, 2'd0, 2'd0, 64'h5A, 4'd0));
    queue_req(make_req(CMD_READ, 2'd3, 2'd0, 64'h0, 4'd0));
    queue_req(make_req(CMD_ALIGN, 2'd0, 2'd0, 64'h0, 4'd7));
    queue_req(make_req(CMD_REWIND, 2'd0, 2'd0, 64'h0, 4'd0));

    // short buffer, big endian default; park the cursor past the length
    set_config(1'b0, 13'd12);
    queue_req(make_req(CMD_READ, 2'd3, 2'd0, 64'h0, 4'd0));
    queue_req(make_req(CMD_READ, 2'd3, 2'd0, 64'h0, 4'd0));
    queue_req(make_req(CMD_READ, 2'd2, 2'd0, 64'h0, 4'd0));
    queue_req(make_req(CMD_ALIGN, 2'd0, 2'd0, 64'h0, 4'd15));
    queue_req(make_req(CMD_WRITE, 2'd0, 2'd0, 64'hFF, 4'd0));
    queue_req(make_req(CMD_REWIND, 2'd0, 2'd0, 64'h0, 4'd0));

    // fill the whole store, then push the cursor past its end
    set_config(1'b1, 13'd4096);
    queue_req(make_req(CMD_REWIND, 2'd0, 2'd0, 64'h0, 4'd0));
    for (i = 0; i < BUF_DEPTH_DEF / 8; i++)
      queue_req(make_req(CMD_WRITE, 2'd3, 2'($urandom_range(0, 3)), rand_value(), 4'd0));
    queue_req(make_req(CMD_READ, 2'd0, 2'd0, 64'h0, 4'd0));
    queue_req(make_req(CMD_ALIGN, 2'd0, 2'd0, 64'h0, 4'd15));
    queue_req(make_req(CMD_WRITE, 2'd0, 2'd0, 64'h1, 4'd0));
    queue_req(make_req(CMD_REWIND, 2'd0, 2'd0, 64'h0, 4'd0));

    for (ph = 0; ph < 8; ph++) begin
      set_config(ph[0], (ph == 5 || ph == 6) ? 13'($urandom_range(0, 4096)) : len_plan[ph]);
      i = pending_q.size();
      while (pending_q.size() - i < 55) begin
        if ($urandom_range(0, 9) < 7) begin
          queue_round_trip();
        end else begin
          repeat ($urandom_range(1, 6)) queue_random(2'($urandom_range(0, 3)));
        end
      end
    end

    drain();
    if (expect_q.size() != 0) bad_count++;
    if (bad_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/cdr_bob_pkg.sv
src/cdr_bob_ram.sv
src/cdr_byte_order_buffer_engine.sv
tb/cdr_byte_order_buffer_engine_test.sv
